// ===== src/sohc_pkg.sv =====
package sohc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NUM_BINS    = 1 << SAMPLE_BITS;
    localparam int DATA_W      = 16;
    localparam int COUNT_W     = 16;
    localparam int WEIGHT_W    = 32;
    localparam int SUM_W       = 48;
    localparam int PROD_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int MEAN_W      = 24;
    localparam int DVD_W       = SUM_W + FRAC_BITS;
    localparam int DIV_STEPS   = MEAN_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [DATA_W-1:0]  MIN_RESET = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0]  MAX_RESET = -16'sh8000;
    localparam logic [COUNT_W-1:0]        THR_RESET = 16'd1;
    localparam logic [COUNT_W-1:0]        COUNT_MAX = '1;
    localparam logic [SAMPLE_BITS-1:0]    BIN_MSB   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef logic [SAMPLE_BITS-1:0] bin_addr_t;

    // one queued command: a sample bin or a finish request
    typedef struct packed {
        logic      finish;
        bin_addr_t addr;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef struct packed {
        logic                start;
        logic                neg;
        logic [SUM_W-1:0]    mag;
        logic [WEIGHT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [MEAN_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } back_state_t;

    // bin address read as a signed reading, widened to the data width
    function automatic logic signed [DATA_W-1:0] bin_value(input bin_addr_t addr);
        logic signed [SAMPLE_BITS-1:0] v;
        v = $signed(addr);
        return DATA_W'(v);
    endfunction

endpackage

// ===== src/sohc_ram.sv =====
module sohc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sohc_div.sv =====
module sohc_div
    import sohc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [WEIGHT_W-1:0] rem_reg, rem_next;
    logic [MEAN_W-1:0]   low_reg, low_next;
    logic [MEAN_W-1:0]   quo_reg, quo_next;
    logic [WEIGHT_W-1:0] dvs_reg, dvs_next;
    logic                neg_reg, neg_next;

    logic [DVD_W-1:0]    dividend;
    logic [WEIGHT_W:0]   trial;
    logic [WEIGHT_W:0]   diff;
    logic                ge;

    assign dividend = {req.mag, {FRAC_BITS{1'b0}}};
    assign trial    = {rem_reg, low_reg[MEAN_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            // upper part is already below the divisor since the quotient fits MEAN_W bits
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[DVD_W-1:MEAN_W];
            low_next  = dividend[MEAN_W-1:0];
            quo_next  = '0;
            dvs_next  = req.divisor;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
            low_next  = {low_reg[MEAN_W-2:0], 1'b0};
            quo_next  = {quo_reg[MEAN_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== src/sohc_front.sv =====
module sohc_front
    import sohc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] sample,
    input  back_ctl_t                ctl,
    output logic                     cmd_valid,
    output cmd_t                     cmd
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              full;
    logic              push;
    logic              pop;
    cmd_t              entry;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign in_stall  = full || ctl.clearing;
    assign push      = in_valid && !in_stall;
    assign cmd_valid = count_reg != '0;
    assign pop       = ctl.pop && cmd_valid;
    assign cmd       = queue_reg[rd_ptr_reg];

    // classify the entry: the low SAMPLE_BITS bits of the reading, here all of it, select a bin
    assign entry.finish = kind;
    assign entry.addr   = sample[SAMPLE_BITS-1:0];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== src/sohc_back.sv =====
module sohc_back
    import sohc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output back_ctl_t                ctl,
    input  logic [COUNT_W-1:0]       threshold,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] min_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic signed [MEAN_W-1:0] mean_q8,
    output logic                     none_qualified
);

    back_state_t state_reg, state_next;
    bin_addr_t   cnt_reg, cnt_next;
    bin_addr_t   addr_reg, addr_next;

    // scan pipeline: stage 1 has the bin count, stage 2 the product
    logic                     p1_valid_reg, p1_valid_next;
    bin_addr_t                p1_addr_reg, p1_addr_next;
    logic                     p2_valid_reg, p2_valid_next;
    logic                     p2_qual_reg, p2_qual_next;
    logic [COUNT_W-1:0]       p2_count_reg, p2_count_next;
    logic signed [DATA_W-1:0] p2_value_reg, p2_value_next;
    logic signed [PROD_W-1:0] p2_prod_reg, p2_prod_next;

    logic [WEIGHT_W-1:0]      weight_reg, weight_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] acc_min_reg, acc_min_next;
    logic signed [DATA_W-1:0] acc_max_reg, acc_max_next;
    logic signed [MEAN_W-1:0] res_mean_reg, res_mean_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_min_reg, out_min_next;
    logic signed [DATA_W-1:0] out_max_reg, out_max_next;
    logic signed [MEAN_W-1:0] out_mean_reg, out_mean_next;
    logic                     out_none_reg, out_none_next;

    logic                     rd_en;
    bin_addr_t                rd_addr;
    logic [COUNT_W-1:0]       rd_data;
    logic                     wr_en;
    bin_addr_t                wr_addr;
    logic [COUNT_W-1:0]       wr_data;

    logic                     start_scan;
    logic                     drained;
    logic                     out_load;
    logic                     none;
    logic signed [DATA_W-1:0] s1_value;
    logic signed [33:0]       s1_prod;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    sohc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sohc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign drained  = !p1_valid_reg && !p2_valid_reg;
    assign none     = weight_reg == '0;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cmd.finish ? ST_SCAN : ST_INC;
                end
            end
            ST_INC:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctl.pop      = (state_reg == ST_IDLE) && cmd_valid;
        ctl.clearing = state_reg == ST_CLEAR;
        start_scan   = ctl.pop && cmd.finish;

        cnt_next = cnt_reg;
        if ((state_reg == ST_CLEAR) || (state_reg == ST_SCAN))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (start_scan)
        begin
            cnt_next = '0;
        end

        addr_next = ctl.pop ? cmd.addr : addr_reg;

        // scan in value order: most negative reading first
        rd_en   = (ctl.pop && !cmd.finish) || (state_reg == ST_SCAN);
        rd_addr = (state_reg == ST_SCAN) ? (cnt_reg ^ BIN_MSB) : cmd.addr;

        p1_valid_next = state_reg == ST_SCAN;
        p1_addr_next  = cnt_reg ^ BIN_MSB;

        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        priority if (p1_valid_reg)
        begin
            // clear each bin right after it is read
            wr_en   = 1'b1;
            wr_addr = p1_addr_reg;
        end
        else if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
        end
        else if (state_reg == ST_INC)
        begin
            wr_en   = 1'b1;
            wr_addr = addr_reg;
            wr_data = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
        end

        div_req.start   = (state_reg == ST_DRAIN) && drained;
        div_req.neg     = sum_reg[SUM_W-1];
        div_req.mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_req.divisor = weight_reg;
    end

    // scan datapath
    always_comb
    begin
        s1_value      = bin_value(p1_addr_reg);
        s1_prod       = $signed({s1_value[DATA_W-1], s1_value})
                        * $signed({1'b0, rd_data});
        p2_valid_next = p1_valid_reg;
        p2_qual_next  = (rd_data != '0) && (rd_data >= threshold);
        p2_count_next = rd_data;
        p2_value_next = s1_value;
        p2_prod_next  = s1_prod[PROD_W-1:0];

        weight_next  = weight_reg;
        sum_next     = sum_reg;
        acc_min_next = acc_min_reg;
        acc_max_next = acc_max_reg;
        if (start_scan)
        begin
            weight_next  = '0;
            sum_next     = '0;
            acc_min_next = MIN_RESET;
            acc_max_next = MAX_RESET;
        end
        else if (p2_valid_reg && p2_qual_reg)
        begin
            weight_next  = weight_reg + WEIGHT_W'(p2_count_reg);
            sum_next     = sum_reg + SUM_W'(p2_prod_reg);
            // ascending scan: first qualifier is the min, last is the max
            acc_min_next = none ? p2_value_reg : acc_min_reg;
            acc_max_next = p2_value_reg;
        end

        res_mean_next = res_mean_reg;
        if ((state_reg == ST_DIV) && div_rsp.done)
        begin
            res_mean_next = none ? '0 : div_rsp.quotient;
        end

        out_valid_next = out_valid_reg && out_stall;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_mean_next  = out_mean_reg;
        out_none_next  = out_none_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_min_next   = acc_min_reg;
            out_max_next   = acc_max_reg;
            out_mean_next  = res_mean_reg;
            out_none_next  = none;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        p1_addr_reg  <= p1_addr_next;
        p2_qual_reg  <= p2_qual_next;
        p2_count_reg <= p2_count_next;
        p2_value_reg <= p2_value_next;
        p2_prod_reg  <= p2_prod_next;
        weight_reg   <= weight_next;
        sum_reg      <= sum_next;
        acc_min_reg  <= acc_min_next;
        acc_max_reg  <= acc_max_next;
        res_mean_reg <= res_mean_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_mean_reg <= out_mean_next;
        out_none_reg <= out_none_next;
    end

    assign out_valid      = out_valid_reg;
    assign min_value      = out_min_reg;
    assign max_value      = out_max_reg;
    assign mean_q8        = out_mean_reg;
    assign none_qualified = out_none_reg;

endmodule

// ===== src/sensor_offset_histogram_calibrator_core.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------
// input     | in_valid / in_stall     | kind, sample
// result    | out_valid / out_stall   | min_value, max_value, mean_q8, none_qualified
// config    | cfg_write               | cfg_data (min_occurrences)
//
// Sample: read-modify-write of its bin in the bin RAM, read at pop, written in ST_INC.
// Finish: pop, scan of all 65536 bins (one bin per cycle), drain of the scan pipeline,
// serial divider (MEAN_W steps and done), then result load into the output registers.
// Reset: a clearing pass writes every bin to zero with in_stall high.
// Stalls: a 4-entry command queue takes input while the back end is busy; samples keep
// retiring under a held result, but the next finish stops the back end in ST_DONE till out_stall drops.
module sensor_offset_histogram_calibrator_core
    import sohc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] min_value,
    output logic signed [DATA_W-1:0] max_value,
    output logic signed [MEAN_W-1:0] mean_q8,
    output logic                     none_qualified,
    input  logic                     cfg_write,
    input  logic [COUNT_W-1:0]       cfg_data
);

    logic [COUNT_W-1:0] min_occ_reg, min_occ_next;
    back_ctl_t          ctl;
    logic               cmd_valid;
    cmd_t               cmd;

    assign min_occ_next = cfg_write ? cfg_data : min_occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_occ_reg <= THR_RESET;
        end
        else
        begin
            min_occ_reg <= min_occ_next;
        end
    end

    sohc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .sample    (sample),
        .ctl       (ctl),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    sohc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .ctl            (ctl),
        .threshold      (min_occ_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_value      (min_value),
        .max_value      (max_value),
        .mean_q8        (mean_q8),
        .none_qualified (none_qualified)
    );

endmodule
